// File: rtl/core/lcse_pkg.sv
// Shared types and constants for the lane centroid steering error block.
// Holds widths, register indexes, controller states and the command and
// status bundles between controller and datapath. No dependencies.
package lcse_pkg;

    // Raster limits
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int COL_POS_W   = COL_IDX_W + 1;  // can hold MAX_COLUMNS itself
    localparam int ROW_POS_W   = ROW_IDX_W + 1;

    // Accumulators
    localparam int ROW_SUM_W   = 20;
    localparam int ROW_CNT_W   = 11;
    localparam int CTR_SUM_W   = 28;
    localparam int ROWS_W      = 11;

    // Shared divider: 28 bit dividend, 11 bit divisor, one quotient bit per cycle
    localparam int DIV_W       = 28;
    localparam int DIVISOR_W   = 11;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    // Payload widths
    localparam int PIXEL_W     = 8;
    localparam int ERR_W       = 20;
    localparam int TURN_W      = 28;
    localparam int SPEED_W     = 16;
    localparam int GAIN_W      = 17;
    localparam int PROD_W      = GAIN_W + ERR_W;

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TOP    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_BOTTOM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_RIGHT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_CENTER  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BIAS_OFFSET   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_STEER_GAIN    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_SPEED = 3'd7;

    // Register reset values
    localparam logic [9:0]         RST_WINDOW_TOP    = 10'd320;
    localparam logic [10:0]        RST_WINDOW_BOTTOM = 11'd344;
    localparam logic [9:0]         RST_WINDOW_LEFT   = 10'd0;
    localparam logic [10:0]        RST_WINDOW_RIGHT  = 11'd640;
    localparam logic [9:0]         RST_IMAGE_CENTER  = 10'd320;
    localparam logic [9:0]         RST_BIAS_OFFSET   = 10'd30;
    localparam logic [GAIN_W-1:0]  RST_STEER_GAIN    = -17'sd983;
    localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = 16'd9830;

    // Controller states, one-hot
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ROW_START = 9'b000000010,
        S_ROW_DIV   = 9'b000000100,
        S_ROW_CLOSE = 9'b000001000,
        S_FRM_START = 9'b000010000,
        S_FRM_DIV   = 9'b000100000,
        S_ERR       = 9'b001000000,
        S_MUL       = 9'b010000000,
        S_OUT       = 9'b100000000
    } lcse_state_t;

    // Controller to datapath
    typedef struct packed {
        logic pix_accept;     // accumulate the pixel of this transaction
        logic row_div_start;  // start sum*256 / count
        logic row_close;      // add row center, clear row state
        logic frm_div_start;  // start center_sum / rows
        logic err_calc;       // form the biased, saturated error
        logic mul_calc;       // gain times error
        logic out_load;       // load result register, clear frame state
    } lcse_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_cnt_nz;     // current row had set pixels
        logic rows_nz;        // frame had rows with a line
        logic div_done;       // divider finishes this cycle
        logic out_free;       // result register can take a new result
    } lcse_sts_t;

endpackage

// File: rtl/core/lcse_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared by the row center and frame average divisions. Uses lcse_pkg.
module lcse_div
    import lcse_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W+1:0] diff;
    logic                 ge;

    // One shift-subtract step
    always_comb begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        ge    = !diff[DIVISOR_W+1];
    end

    assign done     = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_W - 1));
    assign quotient = quot_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quot_next = dividend;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

endmodule

// File: rtl/core/lcse_datapath.sv
// Datapath: configuration registers, row and frame accumulators, shared
// divider, error and turn arithmetic, result register. Uses lcse_pkg, lcse_div.
module lcse_datapath
    import lcse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel payload
    input  logic [PIXEL_W-1:0]    pixel,
    // controller
    input  lcse_cmd_t             cmd,
    output lcse_sts_t             sts,
    // result
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [ERR_W-1:0]      out_err,
    output logic [TURN_W-1:0]     out_turn,
    output logic [SPEED_W-1:0]    out_speed,
    output logic                  out_no_line
);

    // Configuration registers
    logic [9:0]         win_top_reg;
    logic [10:0]        win_bottom_reg;
    logic [9:0]         win_left_reg;
    logic [10:0]        win_right_reg;
    logic [9:0]         img_center_reg;
    logic [9:0]         bias_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_top_reg    <= RST_WINDOW_TOP;
            win_bottom_reg <= RST_WINDOW_BOTTOM;
            win_left_reg   <= RST_WINDOW_LEFT;
            win_right_reg  <= RST_WINDOW_RIGHT;
            img_center_reg <= RST_IMAGE_CENTER;
            bias_reg       <= RST_BIAS_OFFSET;
            gain_reg       <= RST_STEER_GAIN;
            speed_reg      <= RST_FORWARD_SPEED;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WINDOW_TOP:    win_top_reg    <= cfg_wdata[9:0];
                REG_WINDOW_BOTTOM: win_bottom_reg <= cfg_wdata[10:0];
                REG_WINDOW_LEFT:   win_left_reg   <= cfg_wdata[9:0];
                REG_WINDOW_RIGHT:  win_right_reg  <= cfg_wdata[10:0];
                REG_IMAGE_CENTER:  img_center_reg <= cfg_wdata[9:0];
                REG_BIAS_OFFSET:   bias_reg       <= cfg_wdata[9:0];
                REG_STEER_GAIN:    gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_FORWARD_SPEED: speed_reg      <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame state
    logic [COL_POS_W-1:0] col_reg, col_next;
    logic [ROW_POS_W-1:0] row_reg, row_next;
    logic [ROW_SUM_W-1:0] rsum_reg, rsum_next;
    logic [ROW_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [CTR_SUM_W-1:0] csum_reg, csum_next;
    logic [ROWS_W-1:0]    rows_reg, rows_next;

    logic                 col_in, row_in, hit;
    logic [COL_IDX_W-1:0] rel_col;

    // Shared divider
    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend, div_quot;
    logic [DIVISOR_W-1:0] div_divisor;

    assign div_start    = cmd.row_div_start || cmd.frm_div_start;
    assign div_dividend = cmd.row_div_start ? {rsum_reg, 8'h00} : csum_reg;
    assign div_divisor  = cmd.row_div_start ? rcnt_reg : rows_reg;

    lcse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Window test for the current pixel position
    always_comb begin
        col_in  = (col_reg < COL_POS_W'(MAX_COLUMNS)) &&
                  (col_reg >= {1'b0, win_left_reg}) &&
                  (col_reg < win_right_reg);
        row_in  = (row_reg < ROW_POS_W'(MAX_ROWS)) &&
                  (row_reg >= {1'b0, win_top_reg}) &&
                  (row_reg < win_bottom_reg);
        hit     = col_in && row_in && (pixel != '0);
        rel_col = col_reg[COL_IDX_W-1:0] - win_left_reg;
    end

    // Accumulator updates
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        rsum_next = rsum_reg;
        rcnt_next = rcnt_reg;
        csum_next = csum_reg;
        rows_next = rows_reg;
        if (cmd.out_load) begin
            col_next  = '0;
            row_next  = '0;
            rsum_next = '0;
            rcnt_next = '0;
            csum_next = '0;
            rows_next = '0;
        end else if (cmd.row_close) begin
            if (rcnt_reg != '0) begin
                csum_next = csum_reg + div_quot;
                rows_next = rows_reg + 1'b1;
            end
            rsum_next = '0;
            rcnt_next = '0;
            col_next  = '0;
            if (row_reg < ROW_POS_W'(MAX_ROWS)) begin
                row_next = row_reg + 1'b1;
            end
        end else if (cmd.pix_accept) begin
            if (hit) begin
                rsum_next = rsum_reg + ROW_SUM_W'(rel_col);
                rcnt_next = rcnt_reg + 1'b1;
            end
            if (col_reg < COL_POS_W'(MAX_COLUMNS)) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            rsum_reg <= '0;
            rcnt_reg <= '0;
            csum_reg <= '0;
            rows_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rsum_reg <= rsum_next;
            rcnt_reg <= rcnt_next;
            csum_reg <= csum_next;
            rows_reg <= rows_next;
        end
    end

    // Error: average - center, bias pulled toward zero, saturated
    // (the average is below 2^18, so 19 quotient bits are enough)
    logic signed [21:0]      avg_s, ctr_s, bias_s, e0, e1;
    logic signed [ERR_W-1:0] err_sat, err_reg;

    always_comb begin
        avg_s  = signed'({3'b000, div_quot[18:0]});
        ctr_s  = signed'({4'b0000, img_center_reg, 8'h00});
        bias_s = signed'({4'b0000, bias_reg, 8'h00});
        e0     = avg_s - ctr_s;
        e1     = e0[21] ? (e0 + bias_s) : (e0 - bias_s);
        if ((e1[21:ERR_W-1] == '0) || (e1[21:ERR_W-1] == '1)) begin
            err_sat = e1[ERR_W-1:0];
        end else begin
            err_sat = e1[21] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_calc) begin
            err_reg <= rows_reg != '0 ? err_sat : '0;
        end
    end

    // Gain times error
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [GAIN_W-1:0] gain_s;

    assign gain_s = signed'(gain_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_calc) begin
            prod_reg <= PROD_W'(gain_s) * PROD_W'(err_reg);
        end
    end

    // Turn rate: floor(-product / 256), saturated
    logic signed [PROD_W:0]        neg_prod;
    logic        [PROD_W-8:0]      shr;
    logic        [TURN_W-1:0]      turn_sat;

    always_comb begin
        neg_prod = -{prod_reg[PROD_W-1], prod_reg};
        shr      = neg_prod[PROD_W:8];
        if ((shr[PROD_W-8:TURN_W-1] == '0) || (shr[PROD_W-8:TURN_W-1] == '1)) begin
            turn_sat = shr[TURN_W-1:0];
        end else begin
            turn_sat = shr[PROD_W-8] ? {1'b1, {(TURN_W-1){1'b0}}}
                                     : {1'b0, {(TURN_W-1){1'b1}}};
        end
    end

    // Result register
    logic                 out_valid_reg;
    logic [ERR_W-1:0]     out_err_reg;
    logic [TURN_W-1:0]    out_turn_reg;
    logic [SPEED_W-1:0]   out_speed_reg;
    logic                 out_no_line_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_err_reg     <= err_reg;
            out_turn_reg    <= turn_sat;
            out_speed_reg   <= speed_reg;
            out_no_line_reg <= (rows_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_err     = out_err_reg;
    assign out_turn    = out_turn_reg;
    assign out_speed   = out_speed_reg;
    assign out_no_line = out_no_line_reg;

    // Status to controller
    always_comb begin
        sts.row_cnt_nz = (rcnt_reg != '0);
        sts.rows_nz    = (rows_reg != '0);
        sts.div_done   = div_done;
        sts.out_free   = !out_valid_reg || out_ready;
    end

`ifndef NO_ASSERTIONS
    // Divider never started with a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (div_divisor != '0))
        else $error("divider started with zero divisor");

    // A no-line result carries zero error and zero turn
    a_no_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_no_line_reg) |-> (out_err_reg == '0 && out_turn_reg == '0))
        else $error("no-line result with nonzero error or turn");

    // Pixel count of a row cannot exceed the columns seen
    a_cnt_le_col: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= col_reg)
        else $error("row pixel count exceeds column position");
`endif

endmodule

// File: rtl/core/lcse_ctrl.sv
// Controller state machine: pixel acceptance, row close, frame finish and
// result hand-off. Drives the datapath by command bundle. Uses lcse_pkg.
module lcse_ctrl
    import lcse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_last,
    input  logic      in_frame,
    output logic      in_ready,
    input  lcse_sts_t sts,
    output lcse_cmd_t cmd
);

    lcse_state_t state_reg, state_next;
    logic        frame_reg, frame_next;
    logic        in_accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_ready && in_valid;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        frame_next = frame_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.pix_accept = in_accept;
                if (in_accept) begin
                    frame_next = in_frame;
                    if (in_last || in_frame) begin
                        state_next = S_ROW_START;
                    end
                end
            end
            S_ROW_START: begin
                cmd.row_div_start = sts.row_cnt_nz;
                state_next = sts.row_cnt_nz ? S_ROW_DIV : S_ROW_CLOSE;
            end
            S_ROW_DIV: begin
                if (sts.div_done) begin
                    state_next = S_ROW_CLOSE;
                end
            end
            S_ROW_CLOSE: begin
                cmd.row_close = 1'b1;
                state_next = frame_reg ? S_FRM_START : S_IDLE;
            end
            S_FRM_START: begin
                cmd.frm_div_start = sts.rows_nz;
                state_next = sts.rows_nz ? S_FRM_DIV : S_ERR;
            end
            S_FRM_DIV: begin
                if (sts.div_done) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                cmd.err_calc = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_calc = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            frame_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            frame_reg <= frame_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A row or frame end transaction always leads to the row close path
    a_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_last || in_frame)) |=> (state_reg == S_ROW_START))
        else $error("row end not followed by row start");

    // Divider completion only seen while waiting on it
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_ROW_DIV || state_reg == S_FRM_DIV))
        else $error("divider done outside a divide state");

    // Result hand-off returns to pixel acceptance
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && sts.out_free) |=> (state_reg == S_IDLE))
        else $error("result loaded but controller not idle");
`endif

endmodule

// File: rtl/core/lane_centroid_steering_error.sv
// Lane centroid steering error, top level.
// Instantiates lcse_ctrl and lcse_datapath; uses lcse_pkg.
//
// Usage:
//   The input stream carries a binary mask frame in raster order, one pixel
//   per transaction: tdata is the pixel (nonzero = set), tlast marks the last
//   pixel of a row, tuser marks the last pixel of the frame (which also ends
//   the row). One result transaction leaves per frame, after the frame-end
//   pixel: center error, turn rate and forward speed in tdata, no-line in tuser.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata between frames.
//
// Throughput and stalls:
//   Ordinary pixels take one cycle each. After a row-end pixel, s_axis_tready
//   stays low while the row closes, and longer when the row had set pixels:
//   the row center then uses the shared bit-serial divider. After the
//   frame-end pixel the result takes no divider pass without any line, one or
//   two otherwise, then the error, multiply and saturation steps.
//
// Reset and stall:
//   aresetn (synchronous, active low) clears the accumulators, the controller
//   and the result valid, and loads the register defaults. A waiting result
//   holds the block only at the next frame end; pixels keep flowing until then.
module lane_centroid_steering_error
    import lcse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
    input  logic                  s_axis_tlast,   // row_end
    input  logic                  s_axis_tuser,   // [0] frame_end
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [19:0] center_error, [47:20] turn_rate,
                                                  // [63:48] speed_out
    output logic                  m_axis_tuser    // [0] no_line
);

    lcse_cmd_t          cmd;
    lcse_sts_t          sts;
    logic [ERR_W-1:0]   out_err;
    logic [TURN_W-1:0]  out_turn;
    logic [SPEED_W-1:0] out_speed;

    lcse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_frame (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcse_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .pixel       (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_err     (out_err),
        .out_turn    (out_turn),
        .out_speed   (out_speed),
        .out_no_line (m_axis_tuser)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {out_speed, out_turn, out_err};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for lane_centroid_steering_error.
// Streams mask frames, predicts each frame's steering result and checks it.
// Depends on lcse_pkg and the lane_centroid_steering_error RTL.
module testbench;
    import lcse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 80;   // longest frame-end latency plus margin
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // Expected result of one frame
    typedef struct packed {
        logic signed [19:0] center_error;
        logic signed [27:0] turn_rate;
        logic [15:0]        speed_out;
        logic               no_line;
    } steer_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] pixel
    logic                  s_axis_tlast = 1'b0; // row_end
    logic                  s_axis_tuser = 1'b0; // [0] frame_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;        // [19:0] center_error, [47:20] turn_rate,
                                                // [63:48] speed_out
    logic                  m_axis_tuser;        // [0] no_line

    lane_centroid_steering_error u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor copy of the registers, reset values
    logic [9:0]         win_top    = 10'd320;
    logic [10:0]        win_bottom = 11'd344;
    logic [9:0]         win_left   = 10'd0;
    logic [10:0]        win_right  = 11'd640;
    logic [9:0]         img_center = 10'd320;
    logic [9:0]         bias_px    = 10'd30;
    logic signed [16:0] steer_k    = -17'sd983;
    logic [15:0]        fwd_speed  = 16'd9830;

    // Predictor copy of the frame accumulators
    int     col_pos  = 0;
    int     row_pos  = 0;
    longint row_sum  = 0;
    longint row_cnt  = 0;
    longint ctr_sum  = 0;
    longint rows_hit = 0;

    steer_result_t expected_steer[$];

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int mismatches    = 0;
    int pixels_sent   = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int reg_writes    = 0;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Steering predictor: track one accepted pixel, queue the frame result at frame end
    function automatic void lane_predict(logic [7:0] pix, bit row_end, bit frame_end);
        bit            row_in;
        bit            col_in;
        longint        avg;
        longint        err;
        longint        turn;
        steer_result_t res;
        row_in = row_pos < MAX_ROWS && row_pos >= int'(win_top) && row_pos < int'(win_bottom);
        col_in = col_pos < MAX_COLUMNS && col_pos >= int'(win_left)
                 && col_pos < int'(win_right);
        if (row_in && col_in && pix != 8'd0) begin
            row_sum += col_pos - int'(win_left);
            row_cnt++;
        end
        if (col_pos < MAX_COLUMNS)
            col_pos++;

        // row close: add the Q.8 row center
        if (row_end || frame_end) begin
            if (row_cnt != 0) begin
                ctr_sum += (row_sum * 256) / row_cnt;
                rows_hit++;
            end
            row_sum = 0;
            row_cnt = 0;
            col_pos = 0;
            if (row_pos < MAX_ROWS)
                row_pos++;
        end

        if (frame_end) begin
            res.center_error = '0;
            res.turn_rate    = '0;
            res.speed_out    = fwd_speed;
            res.no_line      = 1'b1;
            if (rows_hit != 0) begin
                avg = ctr_sum / rows_hit;
                err = avg - longint'(img_center) * 256;
                // zero error counts as not negative
                if (err < 0)
                    err += longint'(bias_px) * 256;
                else
                    err -= longint'(bias_px) * 256;
                if (err > 524287)
                    err = 524287;
                if (err < -524288)
                    err = -524288;
                turn = (-(longint'(steer_k) * err)) >>> 8;   // floor division
                if (turn > 134217727)
                    turn = 134217727;
                if (turn < -134217728)
                    turn = -134217728;
                res.center_error = err[19:0];
                res.turn_rate    = turn[27:0];
                res.no_line      = 1'b0;
            end
            expected_steer = {expected_steer, res};
            row_pos  = 0;
            ctr_sum  = 0;
            rows_hit = 0;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_W-1:0] addr, logic [16:0] value);
        case (addr)
            REG_WINDOW_TOP:    win_top    = value[9:0];
            REG_WINDOW_BOTTOM: win_bottom = value[10:0];
            REG_WINDOW_LEFT:   win_left   = value[9:0];
            REG_WINDOW_RIGHT:  win_right  = value[10:0];
            REG_IMAGE_CENTER:  img_center = value[9:0];
            REG_BIAS_OFFSET:   bias_px    = value[9:0];
            REG_STEER_GAIN:    steer_k    = value;
            REG_FORWARD_SPEED: fwd_speed  = value[15:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: mismatch on %s, got 0x%0h, expected 0x%0h (frame result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    // Result side: random back-pressure and field-by-field compare
    always @(posedge aclk) begin
        steer_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_steer.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    want = expected_steer.pop_front();
                    if (m_axis_tdata[19:0] !== want.center_error)
                        report_mismatch("center_error", m_axis_tdata[19:0], want.center_error);
                    if (m_axis_tdata[47:20] !== want.turn_rate)
                        report_mismatch("turn_rate", m_axis_tdata[47:20], want.turn_rate);
                    if (m_axis_tdata[63:48] !== want.speed_out)
                        report_mismatch("speed_out", m_axis_tdata[63:48], want.speed_out);
                    if (m_axis_tuser !== want.no_line)
                        report_mismatch("no_line", m_axis_tuser, want.no_line);
                end
                results_seen++;
            end
            m_axis_tready <= !sink_idle_on || ($urandom_range(99) >= 30);
        end
    end

    // One pixel transaction; tvalid stays high into the next call unless it idles
    task automatic send_pixel(input logic [7:0] pix, input bit row_end, input bit frame_end);
        while (src_idle_on && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= row_end;
        s_axis_tuser  <= frame_end;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        lane_predict(pix, row_end, frame_end);
        pixels_sent++;
        if (frame_end)
            frames_sent++;
    endtask

    // Row of random pixels; on the frame's last row tlast is random, tuser closes it
    task automatic send_row(input int len, input int set_pct, input bit last_row);
        logic [7:0] pix;
        bit         is_end;
        for (int i = 0; i < len; i++) begin
            pix    = ($urandom_range(99) < set_pct) ? 8'($urandom_range(255, 1)) : 8'd0;
            is_end = (i == len - 1);
            send_pixel(pix, is_end && (!last_row || $urandom_range(1) == 1),
                       is_end && last_row);
        end
    endtask

    task automatic send_frame(input int rows, input int cols_lo, input int cols_hi,
                              input int set_pct);
        for (int r = 0; r < rows; r++)
            send_row($urandom_range(cols_hi, cols_lo), set_pct, r == rows - 1);
    endtask

    // Stop sending and wait out every pending result plus the block's latency
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (expected_steer.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        apply_reg(addr, value);
        reg_writes++;
    endtask

    // Full register load, only with the block idle
    task automatic configure(input int top, input int bottom, input int left, input int right,
                             input int center, input int bias, input int gain,
                             input int speed);
        drain_results();
        put_reg(REG_WINDOW_TOP,    17'(top));
        put_reg(REG_WINDOW_BOTTOM, 17'(bottom));
        put_reg(REG_WINDOW_LEFT,   17'(left));
        put_reg(REG_WINDOW_RIGHT,  17'(right));
        put_reg(REG_IMAGE_CENTER,  17'(center));
        put_reg(REG_BIAS_OFFSET,   17'(bias));
        put_reg(REG_STEER_GAIN,    17'(gain));
        put_reg(REG_FORWARD_SPEED, 17'(speed));
        cfg_we <= 1'b0;
    endtask

    // Register defaults: a frame tall enough to reach the default window
    task automatic test_reset_defaults;
        send_frame(346, 1, 3, 40);
    endtask

    // Hand-placed pixels: zero error, frame end without row end, empty windows
    task automatic test_directed_frames;
        configure(1, 4, 2, 9, 3, 1, -65536, 65535);
        send_frame(4, 8, 8, 0);                                    // nothing set: no line
        for (int c = 0; c < 10; c++)
            send_pixel(8'hFF, c == 9, 1'b0);                       // above the window
        for (int c = 0; c < 10; c++)
            send_pixel(c == 2 ? 8'h01 : c == 8 ? 8'hFF : c == 9 ? 8'h80 : 8'h00,
                       c == 9, 1'b0);
        for (int c = 0; c < 10; c++)
            send_pixel(8'h00, c == 9, 1'b0);
        for (int c = 0; c < 6; c++)
            send_pixel(c == 5 ? 8'h7F : 8'h00, 1'b0, c == 5);      // error before the bias lands on zero
        send_pixel(8'h01, 1'b1, 1'b1);                             // one-pixel frame

        configure(0, 1, 0, 1, 0, 0, 65535, 0);
        send_pixel(8'h40, 1'b1, 1'b1);                             // line found, zero error
        send_pixel(8'h02, 1'b0, 1'b1);

        // empty windows report no line
        configure(4, 4, 0, 1024, 7, 5, 1000, 123);
        send_frame(6, 1, 8, 90);
        configure(0, 1024, 5, 5, 7, 5, -1000, 456);
        send_frame(3, 1, 8, 90);
        configure(6, 2, 9, 2, 7, 5, 12345, 789);
        send_frame(8, 1, 10, 90);
    endtask

    // Rows and frames longer than the position counters can hold
    task automatic test_overlong_raster;
        configure(0, 1024, 0, 1024, 512, 1023, -65536, 65535);
        send_row(1030, 5, 1'b0);
        for (int r = 1; r < 1024; r++)
            send_row(1, 3, 1'b0);
        send_row(4, 80, 1'b0);
        send_row(4, 80, 1'b0);
        send_row(4, 80, 1'b1);

        configure(1023, 1024, 1023, 1024, 1, 0, 65535, 0);
        for (int r = 0; r < 1023; r++)
            send_row(1, 50, 1'b0);
        send_row(1026, 50, 1'b0);
        send_row(2, 100, 1'b1);
    endtask

    // Random phases: new registers, then mostly well-formed frames with some noise
    task automatic test_random_frames;
        int  phase;
        int  first_pixel;
        int  first_frame;
        int  len;
        int  pct;
        bit  wide;
        phase       = 0;
        first_pixel = pixels_sent;
        first_frame = frames_sent;
        while (pixels_sent - first_pixel < 500 || frames_sent - first_frame < 48) begin
            wide = ($urandom_range(3) == 0);
            configure($urandom_range(4, 0),
                      wide ? 1024 : $urandom_range(7, 0),
                      $urandom_range(5, 0),
                      wide ? 1024 : $urandom_range(12, 0),
                      ($urandom_range(99) < 20) ? $urandom_range(512, 0)
                                                : $urandom_range(12, 0),
                      ($urandom_range(99) < 20) ? $urandom_range(1023, 0)
                                                : $urandom_range(4, 0),
                      $urandom_range(131071, 0),
                      $urandom_range(65535, 0));
            // one phase runs with no idling on either side
            src_idle_on  = (phase != 2);
            sink_idle_on = (phase != 2);
            repeat (6) begin
                if ($urandom_range(9) == 0) begin
                    // noise: random marks anywhere, closed by a frame end
                    len = $urandom_range(40, 1);
                    for (int i = 0; i < len; i++)
                        send_pixel(8'($urandom_range(255, 0)), $urandom_range(99) < 15,
                                   i == len - 1 || $urandom_range(99) < 4);
                end else begin
                    case ($urandom_range(3))
                        0: pct = 0;
                        1: pct = 15;
                        2: pct = 40;
                        default: pct = 90;
                    endcase
                    send_frame($urandom_range(6, 1), 1, 12, pct);
                end
            end
            phase++;
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_frames();
        test_overlong_raster();
        test_random_frames();
        drain_results();
        $display("tb: %0d pixels in %0d frames, %0d frame results checked, %0d register writes",
                 pixels_sent, frames_sent, results_seen, reg_writes);
        $display("tb: covered default window, empty windows, overlong rows and frames, noise");
        if (mismatches == 0 && expected_steer.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
